FILE: rtl/lsf_pkg.sv
// Package for the largest open square finder.
// Field widths, default sizes and reset values used by the top-level rtl file.
// No dependencies.
package lsf_pkg;

  // default grid limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // fixed field widths
  localparam int CFG_W     = 11;
  localparam int CORNER_W  = 10;
  localparam int LEN_W     = 11;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(1024);

  // result item as packed on the output tdata, lowest field last
  typedef struct packed {
    logic [LEN_W-1:0]    square_len;
    logic [CORNER_W-1:0] corner_row;
    logic [CORNER_W-1:0] corner_col;
  } result_t;

endpackage

FILE: rtl/lsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data.
// No dependencies.
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/largest_square_finder_unit.sv
// Largest open square finder, top level.
// Depends on lsf_pkg and lsf_ram.
//
// Usage:
//   The grid streams in on s_axis one cell per item, row by row. tdata[0] is
//   cell_open (1 = open), tlast marks the final cell of the grid. Each row
//   holds row_width cells, set through cfg_wr_en / cfg_wr_data while idle
//   (0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH).
//   On the last cell one result item leaves on m_axis: the upper-left corner
//   and side of the first largest open square (all zero for no open cell).
//   Afterwards the block starts over on a fresh grid.
// Throughput: one item per cycle while the update stage is not held (see
//   Stall). The previous row's sizes sit in a line store RAM read in the
//   accept stage, ahead of the size update; a write to the entry being read
//   in the same cycle is forwarded around the RAM. The result item of a last
//   cell passes the update stage and is then held in the output register.
// Reset: synchronous, clears position, best square and the output register;
//   row_width returns to 1024. The line store is not cleared: the first row
//   never uses it.
// Stall: a pending result holds on m_axis while cells keep flowing in; only
//   a further last cell waits in the update stage until the result is taken.
module largest_square_finder_unit #(
  parameter int MAX_WIDTH  = lsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lsf_pkg::CFG_W-1:0]      cfg_wr_data,    // row_width
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsf_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [0] cell_open, rest zero
  input  logic                           s_axis_tlast,   // is_last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lsf_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [9:0] corner_col,
                                                         // [19:10] corner_row,
                                                         // [30:20] square_len
);

  import lsf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW  = $clog2(MAX_WIDTH + 1);
  localparam int PW  = (CW > RW) ? CW : RW;
  localparam int WCW = (SW > CFG_W) ? SW : CFG_W;
  localparam int XW  = (RW + 1 > SW) ? RW + 1 : SW;

  // configuration
  logic [CFG_W-1:0] row_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // ---------------- accept stage: position and line store read -------------
  logic          in_accept;
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [WCW-1:0] eff_width, col_inc;
  logic          row_end;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (row_width == '0) begin
      eff_width = WCW'(1);
    end else if (WCW'(row_width) > WCW'(MAX_WIDTH)) begin
      eff_width = WCW'(MAX_WIDTH);
    end else begin
      eff_width = WCW'(row_width);
    end
    col_inc = WCW'(col_count) + WCW'(1);
    row_end = (col_inc >= eff_width);
  end

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (s_axis_tlast) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (row_end) begin
      col_count_next = '0;
      if ((RW+1)'(row_count) + (RW+1)'(1) == (RW+1)'(MAX_HEIGHT)) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_count + RW'(1);
      end
    end else begin
      col_count_next = CW'(col_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------- update stage ----------------
  logic          s1_valid, s1_fire;
  logic          s1_open, s1_last, s1_row_end;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          fwd_hit;
  logic [SW-1:0] fwd_data, ram_rd;

  logic          m_valid;
  result_t       m_data;

  // only a last cell can be held, and only behind an untaken result
  assign s1_fire       = s1_valid && (!s1_last || !m_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_open    <= s_axis_tdata[0];
      s1_last    <= s_axis_tlast;
      s1_row_end <= row_end;
      s1_col     <= col_count;
      s1_row     <= row_count;
    end
  end

  logic [SW-1:0] left_size, diag_size, best_len;
  logic [CW-1:0] best_col;
  logic [RW-1:0] best_row;
  logic [SW-1:0] up, min_lu, min3, inc, cap, size;
  logic [CW-1:0] rc_min;
  logic          better;
  logic [SW-1:0] fin_len;
  logic [CW-1:0] fin_col;
  logic [RW-1:0] fin_row;

  // same-entry write in the read cycle: the RAM returns old data, bypass it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_accept) begin
      fwd_hit <= s1_fire && (s1_col == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_data <= size;
    end
  end

  lsf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (size),
    .rd_en   (in_accept),
    .rd_addr (col_count),
    .rd_data (ram_rd)
  );

  always_comb begin
    if (s1_row == '0) begin
      up = '0;
    end else if (fwd_hit) begin
      up = fwd_data;
    end else begin
      up = ram_rd;
    end
    min_lu = (left_size < up) ? left_size : up;
    min3   = (min_lu < diag_size) ? min_lu : diag_size;
    inc    = min3 + SW'(1);
    rc_min = (PW'(s1_row) < PW'(s1_col)) ? CW'(s1_row) : s1_col;
    cap    = SW'(rc_min) + SW'(1);
    if (!s1_open) begin
      size = '0;
    end else if (s1_row == '0 || s1_col == '0) begin
      size = SW'(1);
    end else begin
      size = (inc < cap) ? inc : cap;
    end
    better = (size > best_len);
    if (better) begin
      fin_len = size;
      fin_col = CW'(SW'(s1_col) + SW'(1) - size);
      fin_row = RW'(XW'(s1_row) + XW'(1) - XW'(size));
    end else begin
      fin_len = best_len;
      fin_col = best_col;
      fin_row = best_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_len  <= '0;
      best_col  <= '0;
      best_row  <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        left_size <= '0;
        diag_size <= '0;
        best_len  <= '0;
        best_col  <= '0;
        best_row  <= '0;
      end else begin
        left_size <= s1_row_end ? '0 : size;
        diag_size <= s1_row_end ? '0 : up;
        best_len  <= fin_len;
        best_col  <= fin_col;
        best_row  <= fin_row;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= (s1_fire && s1_last) || (m_valid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      m_data.corner_col <= CORNER_W'(fin_col);
      m_data.corner_row <= CORNER_W'(fin_row);
      m_data.square_len <= LEN_W'(fin_len);
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_DATA_W'(m_data);

  // ---------------- assertions ----------------
  a_stall_only_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |-> s1_last && m_valid && !m_axis_tready)
    else $error("update stage held without a pending result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s1_fire && s1_last))
    else $error("result appeared without a last cell");

  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> best_len == '0 && left_size == '0 && diag_size == '0)
    else $error("grid state not cleared after last cell");

  a_best_grows: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last && better |=> best_len == $past(size))
    else $error("best size not taken from larger square");

endmodule
